/* design/resonant_lowpass_filter_macros.svh */
// Assertion macros for the resonant lowpass filter checker.
// Self-contained; included by the checker file only.
`ifndef RESONANT_LOWPASS_FILTER_MACROS_SVH
`define RESONANT_LOWPASS_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RLPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rlpf_pkg.sv */
// Shared types, widths, codes and saturation helpers for the resonant lowpass filter.
// No dependencies; used by every design file through scoped names.
package rlpf_pkg;

  localparam int FRAC_BITS = 15;
  localparam int SMP_W     = 16;
  localparam int Q_W       = 15;
  localparam int S_W       = 32;              // stage value
  localparam int D_W       = S_W + 1;         // stage difference
  localparam int B_W       = 38;              // multiplier operand (holds t)
  localparam int LO_W      = 19;              // low slice of the operand
  localparam int HI_W      = B_W - LO_W;      // high slice of the operand
  localparam int CHUNK_W   = LO_W + 1;
  localparam int COEF_W    = 20;              // feedback gain / coefficient
  localparam int PROD_W    = COEF_W + 1 + CHUNK_W;
  localparam int ACC_W     = 58;
  localparam int MQ_W      = ACC_W - FRAC_BITS;
  localparam int SUM_W     = MQ_W + 1;

  localparam int DIVS_W    = Q_W + 1;
  localparam int REM_W     = DIVS_W + 1;
  localparam int QUO_W     = Q_W + FRAC_BITS;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = 5;

  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int CFG_IDX_BIT = 2;

  localparam logic [DIVS_W-1:0] ONE_Q15 = DIVS_W'(32768);
  localparam logic [COEF_W-1:0] FB_MAX  = COEF_W'(524287);

  localparam logic REG_RESONANCE = 1'b0;
  localparam logic REG_CUTOFF    = 1'b1;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_in;
    logic                    block_end;
  } smp_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    block_end_out;
  } flt_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MLO,
    ST_MHI,
    ST_UPD
  } state_t;

  typedef enum logic [1:0] {
    PH_FB,
    PH_ONE,
    PH_TWO
  } phase_t;

  typedef struct packed {
    logic load_lo;
    logic add_hi;
  } mac_ctl_t;

  function automatic logic signed [S_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    priority if (&v[SUM_W-1:S_W-1] || ~|v[SUM_W-1:S_W-1]) begin
      sat32 = v[S_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat32 = {1'b1, {(S_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(S_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [S_W-1:0] v);
    priority if (&v[S_W-1:SMP_W-1] || ~|v[S_W-1:SMP_W-1]) begin
      sat16 = v[SMP_W-1:0];
    end else if (v[S_W-1]) begin
      sat16 = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      sat16 = {1'b0, {(SMP_W-1){1'b1}}};
    end
  endfunction

endpackage

/* design/rlpf_gain_div.sv */
// Feedback gain unit: gain = q + floor(q * 2^15 / (2^15 - f)), saturated.
// Restoring divider, one quotient bit per cycle. Uses rlpf_pkg.
module rlpf_gain_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rlpf_pkg::Q_W-1:0]         resonance,
  input  logic [rlpf_pkg::Q_W-1:0]         cutoff,
  output logic                             busy,
  output logic [rlpf_pkg::COEF_W-1:0]      gain
);

  logic [rlpf_pkg::QUO_W-1:0]  quo;
  logic [rlpf_pkg::DIVS_W-1:0] rem;
  logic [rlpf_pkg::DIVS_W-1:0] denom;
  logic [rlpf_pkg::CNT_W-1:0]  count;
  logic [rlpf_pkg::REM_W-1:0]  rem_shift;
  logic [rlpf_pkg::REM_W-1:0]  rem_diff;
  logic                        fits;
  logic [rlpf_pkg::QUO_W:0]    sum;
  logic [rlpf_pkg::COEF_W-1:0] gain_sat;

  assign rem_shift = {rem, quo[rlpf_pkg::QUO_W-1]};
  assign rem_diff  = rem_shift - {1'b0, denom};
  assign fits      = rem_shift >= {1'b0, denom};

  assign sum = {1'b0, quo} + (rlpf_pkg::QUO_W+1)'(resonance);
  assign gain_sat = (sum > (rlpf_pkg::QUO_W+1)'(rlpf_pkg::FB_MAX)) ?
                    rlpf_pkg::FB_MAX : sum[rlpf_pkg::COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      gain  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= rlpf_pkg::CNT_W'(rlpf_pkg::DIV_STEPS);
    end else if (busy) begin
      if (count != '0) begin
        count <= count - 1'b1;
      end else begin
        busy <= 1'b0;
        gain <= gain_sat;
      end
    end
  end

  // Dividend shifts out of quo from the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= {resonance, {rlpf_pkg::FRAC_BITS{1'b0}}};
      rem   <= '0;
      denom <= rlpf_pkg::ONE_Q15 - {1'b0, cutoff};
    end else if (busy && count != '0) begin
      quo <= {quo[rlpf_pkg::QUO_W-2:0], fits};
      rem <= fits ? rem_diff[rlpf_pkg::DIVS_W-1:0] : rem_shift[rlpf_pkg::DIVS_W-1:0];
    end
  end

endmodule

/* design/rlpf_mac.sv */
// Shared multiply-accumulate unit: coefficient times a 38-bit operand,
// taken as a low slice and then a high slice. Uses rlpf_pkg.
module rlpf_mac (
  input  logic                               clk,
  input  rlpf_pkg::mac_ctl_t                 ctl,
  input  logic [rlpf_pkg::COEF_W-1:0]        coef,
  input  logic signed [rlpf_pkg::B_W-1:0]    b,
  output logic signed [rlpf_pkg::ACC_W-1:0]  acc
);

  logic signed [rlpf_pkg::COEF_W:0]    coef_s;
  logic signed [rlpf_pkg::CHUNK_W-1:0] chunk;
  logic signed [rlpf_pkg::PROD_W-1:0]  prod;
  logic signed [rlpf_pkg::ACC_W-1:0]   prod_ext;

  assign coef_s = {1'b0, coef};

  always_comb begin
    if (ctl.add_hi) begin
      chunk = {b[rlpf_pkg::B_W-1], b[rlpf_pkg::B_W-1:rlpf_pkg::LO_W]};
    end else begin
      chunk = {1'b0, b[rlpf_pkg::LO_W-1:0]};
    end
  end

  assign prod     = coef_s * chunk;
  assign prod_ext = {{(rlpf_pkg::ACC_W-rlpf_pkg::PROD_W){prod[rlpf_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (ctl.load_lo) begin
      acc <= prod_ext;
    end else if (ctl.add_hi) begin
      acc <= acc + (prod_ext <<< rlpf_pkg::LO_W);
    end
  end

endmodule

/* design/resonant_lowpass_filter.sv */
// Top level of the two-pole resonant lowpass filter: sequencer, state, config port.
// Uses rlpf_pkg, rlpf_gain_div and rlpf_mac.
//
// Usage:
//   Samples enter on smp_valid/smp_item and are taken at an edge where smp_stall
//   is low; filtered samples leave on flt_valid/flt_item and are taken at an
//   edge where flt_stall is low. One result per sample, in order.
//   One sample at a time: smp_stall stays high from the accepting edge until
//   flt_valid is set. The 21x20 multiplier forms three products, each as a low and a
//   high half, with a difference or update cycle around them.
//   A write to resonance or cutoff restarts the feedback gain divider, which
//   produces one quotient bit a cycle; smp_stall stays high while it runs.
//   Reset clears both registers, both filter stages and the gain, and drops
//   flt_valid. While flt_stall holds a result, the filter takes one more sample
//   and finishes it up to its last update, then waits there until the output
//   register frees.
module resonant_lowpass_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              smp_valid,
  output logic                              smp_stall,
  input  rlpf_pkg::smp_item_t               smp_item,
  output logic                              flt_valid,
  input  logic                              flt_stall,
  output rlpf_pkg::flt_item_t               flt_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rlpf_pkg::ADDR_W-1:0]       paddr,
  input  logic [rlpf_pkg::DATA_W-1:0]       pwdata,
  output logic [rlpf_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  rlpf_pkg::state_t   state;
  rlpf_pkg::state_t   state_next;
  rlpf_pkg::phase_t   phase;
  rlpf_pkg::mac_ctl_t mac_ctl;

  logic [rlpf_pkg::Q_W-1:0]         resonance;
  logic [rlpf_pkg::Q_W-1:0]         cutoff;
  logic                             recalc;
  logic                             div_busy;
  logic                             busy;
  logic [rlpf_pkg::COEF_W-1:0]      gain;
  logic [rlpf_pkg::COEF_W-1:0]      coef;
  logic                             cfg_write;

  logic signed [rlpf_pkg::SMP_W-1:0] x_reg;
  logic                              be_reg;
  logic signed [rlpf_pkg::B_W-1:0]   b_reg;
  logic signed [rlpf_pkg::S_W-1:0]   s1;
  logic signed [rlpf_pkg::S_W-1:0]   s2;

  logic signed [rlpf_pkg::ACC_W-1:0] acc;
  logic signed [rlpf_pkg::MQ_W-1:0]  mulq;
  logic signed [rlpf_pkg::D_W-1:0]   diff;
  logic signed [rlpf_pkg::MQ_W-1:0]  t_val;
  logic signed [rlpf_pkg::SUM_W-1:0] s1_sum;
  logic signed [rlpf_pkg::SUM_W-1:0] s2_sum;
  logic signed [rlpf_pkg::S_W-1:0]   s1_new;
  logic signed [rlpf_pkg::S_W-1:0]   s2_new;

  logic accept;
  logic out_free;
  logic finish;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign prdata    = (paddr[rlpf_pkg::CFG_IDX_BIT] == rlpf_pkg::REG_CUTOFF) ?
                     {{(rlpf_pkg::DATA_W-rlpf_pkg::Q_W){1'b0}}, cutoff} :
                     {{(rlpf_pkg::DATA_W-rlpf_pkg::Q_W){1'b0}}, resonance};

  rlpf_gain_div u_gain_div (
    .clk       (clk),
    .rst       (rst),
    .start     (recalc),
    .resonance (resonance),
    .cutoff    (cutoff),
    .busy      (div_busy),
    .gain      (gain)
  );

  assign busy = recalc | div_busy;

  assign coef = (phase == rlpf_pkg::PH_FB) ? gain :
                {{(rlpf_pkg::COEF_W-rlpf_pkg::Q_W){1'b0}}, cutoff};

  rlpf_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (coef),
    .b    (b_reg),
    .acc  (acc)
  );

  // Datapath around the accumulator; >>> floors toward minus infinity.
  assign mulq   = rlpf_pkg::MQ_W'(acc >>> rlpf_pkg::FRAC_BITS);
  assign diff   = {s1[rlpf_pkg::S_W-1], s1} - {s2[rlpf_pkg::S_W-1], s2};
  assign t_val  = {{(rlpf_pkg::MQ_W-rlpf_pkg::SMP_W){x_reg[rlpf_pkg::SMP_W-1]}}, x_reg}
                - {{(rlpf_pkg::MQ_W-rlpf_pkg::S_W){s1[rlpf_pkg::S_W-1]}}, s1}
                + mulq;
  assign s1_sum = {{(rlpf_pkg::SUM_W-rlpf_pkg::S_W){s1[rlpf_pkg::S_W-1]}}, s1}
                + {mulq[rlpf_pkg::MQ_W-1], mulq};
  assign s2_sum = {{(rlpf_pkg::SUM_W-rlpf_pkg::S_W){s2[rlpf_pkg::S_W-1]}}, s2}
                + {mulq[rlpf_pkg::MQ_W-1], mulq};
  assign s1_new = rlpf_pkg::sat32(s1_sum);
  assign s2_new = rlpf_pkg::sat32(s2_sum);

  assign out_free = ~flt_valid | ~flt_stall;

  // Sequencer outputs
  always_comb begin
    smp_stall       = (state != rlpf_pkg::ST_IDLE) | busy;
    mac_ctl.load_lo = (state == rlpf_pkg::ST_MLO);
    mac_ctl.add_hi  = (state == rlpf_pkg::ST_MHI);
    finish          = (state == rlpf_pkg::ST_UPD) & (phase == rlpf_pkg::PH_TWO) & out_free;
  end

  assign accept = smp_valid & ~smp_stall;

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      rlpf_pkg::ST_IDLE: begin
        if (accept) state_next = rlpf_pkg::ST_DIFF;
      end
      rlpf_pkg::ST_DIFF: state_next = rlpf_pkg::ST_MLO;
      rlpf_pkg::ST_MLO:  state_next = rlpf_pkg::ST_MHI;
      rlpf_pkg::ST_MHI:  state_next = rlpf_pkg::ST_UPD;
      rlpf_pkg::ST_UPD: begin
        unique case (phase)
          rlpf_pkg::PH_FB:  state_next = rlpf_pkg::ST_MLO;
          rlpf_pkg::PH_ONE: state_next = rlpf_pkg::ST_DIFF;
          rlpf_pkg::PH_TWO: begin
            if (out_free) state_next = rlpf_pkg::ST_IDLE;
          end
          default: state_next = rlpf_pkg::ST_IDLE;
        endcase
      end
      default: state_next = rlpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rlpf_pkg::ST_IDLE;
      phase     <= rlpf_pkg::PH_FB;
      flt_valid <= 1'b0;
      s1        <= '0;
      s2        <= '0;
      resonance <= '0;
      cutoff    <= '0;
      recalc    <= 1'b0;
    end else begin
      state  <= state_next;
      recalc <= cfg_write;

      if (cfg_write) begin
        unique case (paddr[rlpf_pkg::CFG_IDX_BIT])
          rlpf_pkg::REG_RESONANCE: resonance <= pwdata[rlpf_pkg::Q_W-1:0];
          rlpf_pkg::REG_CUTOFF:    cutoff    <= pwdata[rlpf_pkg::Q_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        phase <= rlpf_pkg::PH_FB;
      end else if (state == rlpf_pkg::ST_UPD) begin
        unique case (phase)
          rlpf_pkg::PH_FB:  phase <= rlpf_pkg::PH_ONE;
          rlpf_pkg::PH_ONE: begin
            phase <= rlpf_pkg::PH_TWO;
            s1    <= s1_new;
          end
          rlpf_pkg::PH_TWO: begin
            if (finish) s2 <= s2_new;
          end
          default: phase <= rlpf_pkg::PH_FB;
        endcase
      end

      if (finish) begin
        flt_valid <= 1'b1;
      end else if (~flt_stall) begin
        flt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg  <= smp_item.sample_in;
      be_reg <= smp_item.block_end;
    end
    if (state == rlpf_pkg::ST_DIFF) begin
      b_reg <= {{(rlpf_pkg::B_W-rlpf_pkg::D_W){diff[rlpf_pkg::D_W-1]}}, diff};
    end else if (state == rlpf_pkg::ST_UPD && phase == rlpf_pkg::PH_FB) begin
      b_reg <= t_val[rlpf_pkg::B_W-1:0];
    end
    if (finish) begin
      flt_item.sample_out    <= rlpf_pkg::sat16(s2_new);
      flt_item.block_end_out <= be_reg;
    end
  end

endmodule

/* design/rlpf_checker.sv */
// Port-level checker for the resonant lowpass filter, bound to the top level.
// Uses rlpf_pkg and resonant_lowpass_filter_macros.svh.
`include "resonant_lowpass_filter_macros.svh"

module rlpf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              smp_valid,
  input logic                              smp_stall,
  input logic                              flt_valid,
  input logic                              flt_stall,
  input rlpf_pkg::flt_item_t               flt_item,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic                              pready
);

  // A stalled result transaction holds.
  `RLPF_ASSERT_NEXT(a_out_hold, clk, rst, flt_valid && flt_stall,
                    flt_valid && $stable(flt_item), "result changed while stalled")

  // One sample at a time: the block is busy right after taking one.
  `RLPF_ASSERT_NEXT(a_busy_after_accept, clk, rst, smp_valid && !smp_stall,
                    smp_stall, "second sample taken while busy")

  // A register write starts the gain recompute, which blocks samples.
  `RLPF_ASSERT_NEXT(a_busy_after_write, clk, rst, psel && penable && pwrite && pready,
                    smp_stall, "sample path open during gain recompute")

  // A new result only appears out of a busy cycle.
  `RLPF_ASSERT_NOW(a_result_from_work, clk, rst, $rose(flt_valid),
                   $past(smp_stall), "result appeared without work")

endmodule

bind resonant_lowpass_filter rlpf_checker u_rlpf_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for the resonant lowpass filter: directed table, then random phases.
// Depends on rlpf_pkg and resonant_lowpass_filter; predicts every sample in fixed point.
module tb_top;

  localparam int          LATENCY     = 12;
  localparam int          QUIET_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          N_PHASES    = 12;
  localparam int          PHASE_ITEMS = 100;
  localparam int          N_ROWS      = 30;
  localparam logic [31:0] Q15_MAX     = 32'h0000_7FFF;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 reg_idx;
    logic [31:0]          data;
    rlpf_pkg::smp_item_t  item;
    bit                   typed;
    rlpf_pkg::flt_item_t  out;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        smp_valid = 1'b0;
  logic        smp_stall;
  rlpf_pkg::smp_item_t smp_item = '0;
  logic        flt_valid;
  logic        flt_stall = 1'b0;
  rlpf_pkg::flt_item_t flt_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [rlpf_pkg::ADDR_W-1:0] paddr = '0;
  logic [rlpf_pkg::DATA_W-1:0] pwdata = '0;
  logic [rlpf_pkg::DATA_W-1:0] prdata;
  logic        pready;

  // filter model state
  logic [rlpf_pkg::Q_W-1:0]    res_q;
  logic [rlpf_pkg::Q_W-1:0]    cut_f;
  logic [rlpf_pkg::COEF_W-1:0] fb_gain;
  longint            stage_a;
  longint            stage_b;

  rlpf_pkg::flt_item_t expected_samples[$];
  int        errors = 0;
  int        quiet = 0;
  bit        jitter_on = 1'b1;
  int        hold_req = 0;
  int        hold_done = 0;
  int        hold_cnt = 0;
  row_t      dir_rows [N_ROWS];

  resonant_lowpass_filter u_top (
    .clk(clk), .rst(rst),
    .smp_valid(smp_valid), .smp_stall(smp_stall), .smp_item(smp_item),
    .flt_valid(flt_valid), .flt_stall(flt_stall), .flt_item(flt_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic longint mul_floor(longint a, longint b);
    return (a * b) >>> rlpf_pkg::FRAC_BITS;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [rlpf_pkg::SMP_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[rlpf_pkg::SMP_W-1:0];
  endfunction

  function automatic void reset_model();
    res_q   = '0;
    cut_f   = '0;
    fb_gain = '0;
    stage_a = 0;
    stage_b = 0;
  endfunction

  // register update: mask to 15 bits, then recompute the held feedback gain
  function automatic void write_model(logic reg_idx, logic [31:0] data);
    longint ratio;
    longint sum;
    if (reg_idx == rlpf_pkg::REG_RESONANCE) res_q = data[rlpf_pkg::Q_W-1:0];
    else cut_f = data[rlpf_pkg::Q_W-1:0];
    ratio = (longint'(res_q) << rlpf_pkg::FRAC_BITS) / (64'sd32768 - longint'(cut_f));
    sum = longint'(res_q) + ratio;
    if (sum > longint'(rlpf_pkg::FB_MAX)) sum = longint'(rlpf_pkg::FB_MAX);
    fb_gain = sum[rlpf_pkg::COEF_W-1:0];
  endfunction

  function automatic rlpf_pkg::flt_item_t lowpass_next(rlpf_pkg::smp_item_t it);
    longint              x;
    longint              t;
    rlpf_pkg::flt_item_t r;
    x = longint'($signed(it.sample_in));
    t = x - stage_a + mul_floor(longint'(fb_gain), stage_a - stage_b);
    stage_a = clamp32(stage_a + mul_floor(longint'(cut_f), t));
    stage_b = clamp32(stage_b + mul_floor(longint'(cut_f), stage_a - stage_b));
    r.sample_out    = clamp16(stage_b);
    r.block_end_out = it.block_end;
    return r;
  endfunction

  function automatic row_t mk_wr(logic reg_idx, logic [31:0] data);
    row_t r;
    r = '{kind: ROW_WRITE, reg_idx: reg_idx, data: data, item: '0, typed: 1'b0, out: '0};
    return r;
  endfunction

  function automatic row_t mk_smp(logic signed [15:0] s, logic be);
    row_t r;
    r = '{kind: ROW_SAMPLE, reg_idx: 1'b0, data: '0, item: {s, be}, typed: 1'b0, out: '0};
    return r;
  endfunction

  function automatic row_t mk_typed(logic signed [15:0] s, logic be,
                                    logic signed [15:0] y);
    row_t r;
    r = mk_smp(s, be);
    r.typed = 1'b1;
    r.out = {y, be};
    return r;
  endfunction

  task automatic cfg_write(logic reg_idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    write_model(reg_idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // offer one sample; valid stays high on return so the next one can follow at once
  task automatic send_sample(rlpf_pkg::smp_item_t it, bit typed,
                             rlpf_pkg::flt_item_t typed_out);
    int                  gap;
    rlpf_pkg::flt_item_t pred;
    gap = 0;
    if (jitter_on) while ($urandom_range(0, 99) < 33) gap++;
    if (gap != 0) begin
      smp_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_valid <= 1'b1;
    smp_item  <= it;
    do @(posedge clk); while (smp_stall);
    pred = lowpass_next(it);
    expected_samples.push_back(typed ? typed_out : pred);
  endtask

  task automatic drain();
    smp_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  function automatic rlpf_pkg::smp_item_t rand_sample();
    rlpf_pkg::smp_item_t it;
    int                  pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) it.sample_in = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    else if (pick < 30) it.sample_in = 16'($signed($urandom_range(0, 511)) - 256);
    else it.sample_in = 16'($urandom);
    it.block_end = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  // receiver: random stall, plus one long hold-off per request counted here
  always @(posedge clk) begin
    if (hold_req != hold_done && hold_cnt == 0) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
      flt_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      flt_stall <= 1'b1;
    end else begin
      flt_stall <= jitter_on && ($urandom_range(0, 99) < 33);
    end
  end

  // compare each delivered transaction with the oldest expectation
  always @(posedge clk) begin
    rlpf_pkg::flt_item_t exp_item;
    if (!rst && flt_valid && !flt_stall) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result: sample_out %0d block_end_out %0b",
               flt_item.sample_out, flt_item.block_end_out);
        errors++;
      end else begin
        exp_item = expected_samples.pop_front();
        if (flt_item.sample_out !== exp_item.sample_out) begin
          $error("sample_out: expected %0d, actual %0d",
                 exp_item.sample_out, flt_item.sample_out);
          errors++;
        end
        if (flt_item.block_end_out !== exp_item.block_end_out) begin
          $error("block_end_out: expected %0b, actual %0b",
                 exp_item.block_end_out, flt_item.block_end_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((smp_valid && !smp_stall) || (flt_valid && !flt_stall) ||
          (psel && penable && pready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] q_val;
    logic [31:0] f_val;
    int          mode;
    // stages stay at zero while cutoff is zero, so those outputs are known
    dir_rows = '{
      mk_typed(16'sh8000, 1'b0, 16'sd0),
      mk_typed(16'sh7FFF, 1'b1, 16'sd0),
      mk_typed(16'sd0,    1'b0, 16'sd0),
      mk_wr(rlpf_pkg::REG_RESONANCE, 32'hFFFF_FFFF),
      mk_typed(16'sh7FFF, 1'b1, 16'sd0),
      mk_typed(-16'sd1,   1'b0, 16'sd0),
      mk_wr(rlpf_pkg::REG_CUTOFF, Q15_MAX),
      mk_smp(16'sh7FFF, 1'b0), mk_smp(16'sh7FFF, 1'b0), mk_smp(16'sh8000, 1'b1),
      mk_smp(16'sh8000, 1'b0), mk_smp(16'sh7FFF, 1'b0), mk_smp(16'sh8000, 1'b0),
      mk_smp(16'sh7FFF, 1'b0), mk_smp(16'sh8000, 1'b0), mk_smp(16'sh7FFF, 1'b1),
      mk_smp(16'sh7FFF, 1'b0),
      mk_wr(rlpf_pkg::REG_CUTOFF, 32'hFFFF_8000),
      mk_smp(16'sd1234, 1'b0), mk_smp(-16'sd1234, 1'b1),
      mk_wr(rlpf_pkg::REG_RESONANCE, 32'h0000_0000),
      mk_wr(rlpf_pkg::REG_CUTOFF, 32'h0000_4000),
      mk_smp(16'sh7FFF, 1'b0), mk_smp(16'sh7FFF, 1'b0), mk_smp(16'sd0, 1'b0),
      mk_smp(16'sh8000, 1'b1), mk_smp(16'sh8000, 1'b0),
      mk_wr(rlpf_pkg::REG_RESONANCE, 32'h0000_4000),
      mk_smp(16'sd100, 1'b0), mk_smp(-16'sd100, 1'b1)
    };
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].data);
      end else begin
        send_sample(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].out);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      // extremes first, then random settings with random upper bits
      mode = ph;
      unique case (mode)
        0: begin
          q_val = 32'h0;
          f_val = 32'h0;
        end
        1: begin
          q_val = Q15_MAX;
          f_val = Q15_MAX;
        end
        2: begin
          q_val = Q15_MAX;
          f_val = 32'h0;
        end
        3: begin
          q_val = 32'h0;
          f_val = Q15_MAX;
        end
        default: begin
          q_val = $urandom;
          f_val = $urandom;
          if (ph % 2 == 0) q_val[14:13] = 2'b00;
        end
      endcase
      jitter_on <= (ph != 5);
      cfg_write(rlpf_pkg::REG_RESONANCE, q_val);
      cfg_write(rlpf_pkg::REG_CUTOFF, f_val);
      if (ph == 2 || ph == 8) hold_req <= hold_req + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(rand_sample(), 1'b0, '0);
    end

    drain();
    repeat (3 * LATENCY) @(posedge clk);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/rlpf_pkg.sv
design/rlpf_gain_div.sv
design/rlpf_mac.sv
design/resonant_lowpass_filter.sv
design/rlpf_checker.sv
bench/tb_top.sv
